>>> rtl/core/fnsp_pkg.sv
// Shared types, constants and helpers of the FASTA stream parser.
// Used by every module in rtl/core except fnsp_queue; depends on nothing.
`timescale 1ns / 1ps

package fnsp_pkg;

   localparam int LENGTH_BITS_DEFAULT = 24;
   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int OUT_LEN_BITS        = 24;

   localparam logic [7:0] CHAR_GT      = 8'h3E; // '>'
   localparam logic [7:0] CHAR_SEMI    = 8'h3B; // ';'
   localparam logic [7:0] CHAR_AMP     = 8'h26; // '&'
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A; // '\n'

   localparam logic [1:0] KIND_SYMBOL = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_END    = 2'd2;

   localparam logic [2:0] BASE_A     = 3'd0;
   localparam logic [2:0] BASE_C     = 3'd1;
   localparam logic [2:0] BASE_G     = 3'd2;
   localparam logic [2:0] BASE_T     = 3'd3;
   localparam logic [2:0] BASE_OTHER = 3'd4;

   typedef enum logic [2:0] {
      CLS_EOI,
      CLS_GT,
      CLS_NEWLINE,
      CLS_SEMI,
      CLS_SYMBOL,
      CLS_OTHER
   } fnsp_class_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_input;
   } fnsp_req_type;

   typedef struct packed {
      logic [1:0]              item_kind;
      logic [7:0]              char_out;
      logic [2:0]              base_code;
      logic                    record_status;
      logic [OUT_LEN_BITS-1:0] sequence_length;
      logic [OUT_LEN_BITS-1:0] header_length;
   } fnsp_rsp_type;

   // Classified byte handed from the front to the back.
   typedef struct packed {
      fnsp_class_type cls;
      logic [7:0]     raw;
      logic [7:0]     upper;
      logic [2:0]     base;
   } fnsp_cmd_type;

   function automatic logic [2:0] base_of(input logic [7:0] u);
      logic [2:0] code;
      case (u)
         8'h41, 8'h30:        code = BASE_A; // 'A', '0'
         8'h43, 8'h31:        code = BASE_C; // 'C', '1'
         8'h47, 8'h32:        code = BASE_G; // 'G', '2'
         8'h54, 8'h55, 8'h33: code = BASE_T; // 'T', 'U', '3'
         default:             code = BASE_OTHER;
      endcase
      return code;
   endfunction

endpackage

>>> rtl/core/fasta_nucleotide_stream_parser.sv
// FASTA stream parser, one text byte per beat.
// Input queue side: drive req_data and raise push; the beat is taken at a
//    rising edge with push high and full low. end_of_input closes the
//    stream: it always yields one record-end result and restarts parsing.
// Result queue side: while empty is low, rsp_data shows the oldest result;
//    it is taken at a rising edge with pop high and empty low.
// Each byte gives zero or one result: a sequence symbol, a header name
//    byte or a record end with the saturating lengths.
// Throughput: one byte per cycle while the result queue has room, set by
//    the state update in the back end. A result passes through the command
//    queue, then the result queue, before it shows on rsp_data, and can
//    then be popped at a rising edge with pop high.
// Reset (synchronous, active high) empties both queues and returns the
//    parser to the start-of-line state with zero counts.
// When the receiver stalls, results collect in the result queue; once it
//    fills, the back end holds, the command queue fills and full rises.
//    No beat is ever dropped.
// Depends on fnsp_pkg, fnsp_front, fnsp_queue and fnsp_back.
`timescale 1ns / 1ps

module fasta_nucleotide_stream_parser
   import fnsp_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  fnsp_req_type req_data,
   output logic         full,
   output logic         empty,
   input  logic         pop,
   output fnsp_rsp_type rsp_data
);

   localparam int CMD_BITS = $bits(fnsp_cmd_type);
   localparam int RSP_BITS = $bits(fnsp_rsp_type);

   fnsp_cmd_type front_cmd, back_cmd;
   logic         cmd_empty, cmd_take;
   fnsp_rsp_type back_rsp;
   logic         back_valid, rsp_full;
   logic [CMD_BITS-1:0] cmd_bits;
   logic [RSP_BITS-1:0] rsp_bits;

   fnsp_front u_front (
      .req (req_data),
      .cmd (front_cmd)
   );

   fnsp_queue #(
      .DATA_BITS (CMD_BITS),
      .DEPTH     (QUEUE_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (front_cmd),
      .full      (full),
      .pop       (cmd_take),
      .pop_data  (cmd_bits),
      .empty     (cmd_empty)
   );

   assign back_cmd = fnsp_cmd_type'(cmd_bits);

   fnsp_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (back_cmd),
      .cmd_valid (!cmd_empty),
      .cmd_take  (cmd_take),
      .rsp       (back_rsp),
      .rsp_valid (back_valid),
      .rsp_full  (rsp_full)
   );

   fnsp_queue #(
      .DATA_BITS (RSP_BITS),
      .DEPTH     (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_valid),
      .push_data (back_rsp),
      .full      (rsp_full),
      .pop       (pop),
      .pop_data  (rsp_bits),
      .empty     (empty)
   );

   assign rsp_data = fnsp_rsp_type'(rsp_bits);

endmodule

>>> rtl/core/fnsp_queue.sv
// Small flip-flop queue with push/full and pop/empty sides.
// Generic payload width; no package dependency.
`timescale 1ns / 1ps

module fnsp_queue #(
   parameter int DATA_BITS = 8,
   parameter int DEPTH     = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 full,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] pop_data,
   output logic                 empty
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_BITS-1:0] LAST_PTR = PTR_BITS'(DEPTH - 1);
   localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(DEPTH);

   logic [DATA_BITS-1:0] store_ff [DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign pop_data = store_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/core/fnsp_front.sv
// Front end: sorts each incoming beat into a byte class, upper-cases
// symbols and looks up the base code. Depends on fnsp_pkg.
`timescale 1ns / 1ps

module fnsp_front
   import fnsp_pkg::*;
(
   input  fnsp_req_type req,
   output fnsp_cmd_type cmd
);

   logic [7:0] b;
   logic       is_lower, is_upper, is_digit;

   assign b        = req.text_byte;
   assign is_lower = (b >= 8'h61) && (b <= 8'h7A);
   assign is_upper = (b >= 8'h41) && (b <= 8'h5A);
   assign is_digit = (b >= 8'h30) && (b <= 8'h39);

   always_comb begin
      cmd.raw   = b;
      cmd.upper = is_lower ? (b - 8'd32) : b;
      cmd.base  = base_of(cmd.upper);
      if (req.end_of_input) begin
         cmd.cls = CLS_EOI;
      end else if (b == CHAR_GT) begin
         cmd.cls = CLS_GT;
      end else if (b == CHAR_NEWLINE) begin
         cmd.cls = CLS_NEWLINE;
      end else if (b == CHAR_SEMI) begin
         cmd.cls = CLS_SEMI;
      end else if (is_lower || is_upper || is_digit || b == CHAR_AMP) begin
         cmd.cls = CLS_SYMBOL;
      end else begin
         cmd.cls = CLS_OTHER;
      end
   end

endmodule

>>> rtl/core/fnsp_back.sv
// Back end: holds the parser state and record counters, and turns each
// classified byte into zero or one result. Depends on fnsp_pkg.
`timescale 1ns / 1ps

module fnsp_back
   import fnsp_pkg::*;
#(
   parameter int LENGTH_BITS = LENGTH_BITS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  fnsp_cmd_type cmd,
   input  logic         cmd_valid,
   output logic         cmd_take,
   output fnsp_rsp_type rsp,
   output logic         rsp_valid,
   input  logic         rsp_full
);

   logic                   prev_nl_ff, prev_nl_in;
   logic                   in_hdr_ff, in_hdr_in;
   logic                   stop_ff, stop_in;
   logic [LENGTH_BITS-1:0] sym_cnt_ff, sym_cnt_in;
   logic [LENGTH_BITS-1:0] hdr_cnt_ff, hdr_cnt_in;
   logic [LENGTH_BITS-1:0] sym_rep, hdr_rep;
   logic [OUT_LEN_BITS-1:0] sym_out, hdr_out;
   logic                   emit;

   assign cmd_take = cmd_valid && !rsp_full;

   generate
      if (LENGTH_BITS >= OUT_LEN_BITS) begin : g_trunc
         assign sym_out = sym_rep[OUT_LEN_BITS-1:0];
         assign hdr_out = hdr_rep[OUT_LEN_BITS-1:0];
      end else begin : g_extend
         assign sym_out = {{(OUT_LEN_BITS-LENGTH_BITS){1'b0}}, sym_rep};
         assign hdr_out = {{(OUT_LEN_BITS-LENGTH_BITS){1'b0}}, hdr_rep};
      end
   endgenerate

   always_comb begin
      prev_nl_in = prev_nl_ff;
      in_hdr_in  = in_hdr_ff;
      stop_in    = stop_ff;
      sym_cnt_in = sym_cnt_ff;
      hdr_cnt_in = hdr_cnt_ff;
      sym_rep    = sym_cnt_ff;
      hdr_rep    = hdr_cnt_ff;
      emit       = 1'b0;
      rsp.item_kind     = KIND_END;
      rsp.char_out      = '0;
      rsp.base_code     = '0;
      rsp.record_status = 1'b0;

      if (cmd.cls == CLS_EOI) begin
         emit              = 1'b1;
         rsp.record_status = (sym_cnt_ff == '0);
         prev_nl_in = 1'b1;
         in_hdr_in  = 1'b0;
         stop_in    = 1'b0;
         sym_cnt_in = '0;
         hdr_cnt_in = '0;
      end else if (!stop_ff) begin
         if (prev_nl_ff && cmd.cls == CLS_GT) begin
            // close the open record first if it has symbols
            if (sym_cnt_ff != '0) begin
               emit       = 1'b1;
               sym_cnt_in = '0;
               hdr_cnt_in = '0;
            end
            in_hdr_in  = 1'b1;
            prev_nl_in = 1'b0;
         end else if (cmd.cls == CLS_NEWLINE) begin
            in_hdr_in  = 1'b0;
            prev_nl_in = 1'b1;
         end else if (!in_hdr_ff) begin
            prev_nl_in = 1'b0;
            if (cmd.cls == CLS_SYMBOL) begin
               sym_cnt_in = (sym_cnt_ff == '1) ? sym_cnt_ff : sym_cnt_ff + 1'b1;
               sym_rep    = sym_cnt_in;
               emit       = 1'b1;
               rsp.item_kind = KIND_SYMBOL;
               rsp.char_out  = cmd.upper;
               rsp.base_code = cmd.base;
            end else if (cmd.cls == CLS_SEMI) begin
               stop_in    = 1'b1;
               prev_nl_in = prev_nl_ff;
            end
         end else begin
            hdr_cnt_in = (hdr_cnt_ff == '1) ? hdr_cnt_ff : hdr_cnt_ff + 1'b1;
            hdr_rep    = hdr_cnt_in;
            emit       = 1'b1;
            prev_nl_in = 1'b0;
            rsp.item_kind = KIND_HEADER;
            rsp.char_out  = cmd.raw;
         end
      end

      rsp.sequence_length = sym_out;
      rsp.header_length   = hdr_out;
      rsp_valid           = cmd_take && emit;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_nl_ff <= 1'b1;
         in_hdr_ff  <= 1'b0;
         stop_ff    <= 1'b0;
         sym_cnt_ff <= '0;
         hdr_cnt_ff <= '0;
      end else if (cmd_take) begin
         prev_nl_ff <= prev_nl_in;
         in_hdr_ff  <= in_hdr_in;
         stop_ff    <= stop_in;
         sym_cnt_ff <= sym_cnt_in;
         hdr_cnt_ff <= hdr_cnt_in;
      end
   end

endmodule

>>> rtl/core/fnsp_checker.sv
// Port-level checks for the FASTA stream parser, bound to the top level.
// Depends on fnsp_pkg.
`timescale 1ns / 1ps

module fnsp_checker
   import fnsp_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         full,
   input logic         empty,
   input logic         pop,
   input fnsp_rsp_type rsp_data
);

   // reset leaves both queues drained
   a_reset_drains: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("queues not drained after reset");

   a_end_payload: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.item_kind == KIND_END) |->
         (rsp_data.char_out == 8'h00 && rsp_data.base_code == BASE_A))
      else $error("record end carries a character or base code");

   a_empty_record: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.item_kind == KIND_END && rsp_data.record_status) |->
         (rsp_data.sequence_length == '0))
      else $error("empty record reports a nonzero sequence length");

   a_symbol_fields: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.item_kind != KIND_END) |->
         (!rsp_data.record_status && rsp_data.base_code <= BASE_OTHER &&
          (rsp_data.item_kind == KIND_SYMBOL || rsp_data.item_kind == KIND_HEADER)))
      else $error("malformed symbol or header result");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("stalled result changed");

endmodule

bind fasta_nucleotide_stream_parser fnsp_checker u_fnsp_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);

>>> tb/fasta_nucleotide_stream_parser_test.sv
// Testbench for fasta_nucleotide_stream_parser: directed and random text streams.
// A scoreboard class predicts each result; plain tasks drive the input side and an initial loop pops.
// Depends on fnsp_pkg and the parser RTL.
`timescale 1ns / 1ps

module fasta_nucleotide_stream_parser_test;
   import fnsp_pkg::*;

   localparam int         COUNT_BITS     = LENGTH_BITS_DEFAULT;
   localparam int         RANDOM_ITEMS   = 700;
   localparam int         CYCLE_LIMIT    = 500000;
   localparam int         TAIL_CYCLES    = 24;
   localparam int         MAX_REPORTS    = 10;
   localparam logic [7:0] NO_CHAR        = 8'h00;
   localparam logic [2:0] NO_BASE        = 3'd0;

   class fasta_scoreboard;
      bit                    after_newline;
      bit                    in_header;
      bit                    halted;
      logic [COUNT_BITS-1:0] symbol_count;
      logic [COUNT_BITS-1:0] header_count;
      fnsp_rsp_type          expected_q[$];
      int                    mismatches;

      function new();
         mismatches = 0;
         restart();
      endfunction

      function void restart();
         after_newline = 1'b1;
         in_header     = 1'b0;
         halted        = 1'b0;
         symbol_count  = '0;
         header_count  = '0;
      endfunction

      function void add(logic [1:0] kind, logic [7:0] ch, logic [2:0] base, logic status);
         fnsp_rsp_type r;
         r.item_kind       = kind;
         r.char_out        = ch;
         r.base_code       = base;
         r.record_status   = status;
         r.sequence_length = OUT_LEN_BITS'(symbol_count);
         r.header_length   = OUT_LEN_BITS'(header_count);
         expected_q.push_back(r);
      endfunction

      // Returns how many results the accepted beat produces.
      function int note_beat(fnsp_req_type beat);
         logic [7:0] b;
         logic [7:0] up;
         logic [2:0] base;
         int         made;
         b    = beat.text_byte;
         made = 0;
         if (beat.end_of_input) begin
            add(KIND_END, NO_CHAR, NO_BASE, symbol_count == '0);
            restart();
            return 1;
         end
         if (halted) return 0;
         if (after_newline && b == CHAR_GT) begin
            if (symbol_count != '0) begin
               add(KIND_END, NO_CHAR, NO_BASE, 1'b0);
               made         = 1;
               symbol_count = '0;
               header_count = '0;
            end
            in_header = 1'b1;
         end else if (b == CHAR_NEWLINE) begin
            in_header = 1'b0;
         end else if (!in_header) begin
            if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") ||
                (b >= "0" && b <= "9") || b == CHAR_AMP) begin
               up = (b >= "a" && b <= "z") ? b - 8'd32 : b;
               case (up)
                  "A", "0":      base = BASE_A;
                  "C", "1":      base = BASE_C;
                  "G", "2":      base = BASE_G;
                  "T", "U", "3": base = BASE_T;
                  default:       base = BASE_OTHER;
               endcase
               if (!(&symbol_count)) symbol_count++;
               add(KIND_SYMBOL, up, base, 1'b0);
               made = 1;
            end else if (b == CHAR_SEMI) begin
               halted = 1'b1;
               return 0;
            end
         end else begin
            if (!(&header_count)) header_count++;
            add(KIND_HEADER, b, NO_BASE, 1'b0);
            made = 1;
         end
         after_newline = (b == CHAR_NEWLINE);
         return made;
      endfunction

      function void check_result(fnsp_rsp_type got);
         fnsp_rsp_type want;
         if (expected_q.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result: kind %0d char %h base %0d status %0b seq %0d hdr %0d",
                        got.item_kind, got.char_out, got.base_code, got.record_status,
                        got.sequence_length, got.header_length);
            return;
         end
         want = expected_q.pop_front();
         if (got.item_kind !== want.item_kind || got.char_out !== want.char_out ||
             got.base_code !== want.base_code || got.record_status !== want.record_status ||
             got.sequence_length !== want.sequence_length ||
             got.header_length !== want.header_length) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
               $display("mismatch: expected kind %0d char %h base %0d status %0b seq %0d hdr %0d",
                        want.item_kind, want.char_out, want.base_code, want.record_status,
                        want.sequence_length, want.header_length);
               $display("          actual   kind %0d char %h base %0d status %0b seq %0d hdr %0d",
                        got.item_kind, got.char_out, got.base_code, got.record_status,
                        got.sequence_length, got.header_length);
            end
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic         clock    = 1'b0;
   logic         reset    = 1'b1;
   logic         push     = 1'b0;
   fnsp_req_type req_data = '0;
   logic         full;
   logic         empty;
   logic         pop      = 1'b0;
   fnsp_rsp_type rsp_data;

   fasta_scoreboard tracker = new();
   int              sent_beats = 0;
   int              push_calm = 0;
   int              pop_calm  = 0;
   int              cycle_count = 0;
   int              pop_gap;

   fasta_nucleotide_stream_parser u_top (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .req_data (req_data),
      .full     (full),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Mostly random waits, with occasional calm stretches of back-to-back beats.
   function automatic int draw_gap(inout int calm_left);
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm_left = $urandom_range(10, 60);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   task automatic send_beat(input logic [7:0] text, input logic eoi);
      fnsp_req_type beat;
      int           gap;
      beat.text_byte    = text;
      beat.end_of_input = eoi;
      gap = draw_gap(push_calm);
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= beat;
      @(posedge clock);
      while (full) @(posedge clock);
      void'(tracker.note_beat(beat));
      sent_beats++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
   endtask

   function automatic logic [7:0] symbol_byte();
      string alphabet;
      alphabet = "ACGTUacgtu0123&NnXz9";
      if ($urandom_range(0, 4) == 0)
         return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
      return alphabet[$urandom_range(0, alphabet.len() - 1)];
   endfunction

   function automatic logic [7:0] header_byte();
      if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
      return 8'($urandom_range(8'h20, 8'h7E));
   endfunction

   // One record: optional header line, a few sequence lines, then an optional close.
   task automatic random_record();
      int len;
      int lines;
      if ($urandom_range(0, 4) != 0) begin
         send_beat(CHAR_GT, 1'b0);
         len = $urandom_range(0, 12);
         repeat (len) send_beat(header_byte(), 1'b0);
         send_beat(CHAR_NEWLINE, 1'b0);
      end
      lines = $urandom_range(0, 3);
      repeat (lines) begin
         len = $urandom_range(0, 20);
         repeat (len)
            send_beat(($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : symbol_byte(),
                      1'b0);
         send_beat(CHAR_NEWLINE, 1'b0);
      end
      case ($urandom_range(0, 7))
         0: begin
            send_beat(CHAR_SEMI, 1'b0);
            repeat ($urandom_range(0, 5)) send_beat(8'($urandom_range(0, 255)), 1'b0);
            send_beat(8'($urandom_range(0, 255)), 1'b1);
         end
         1, 2: send_beat(8'($urandom_range(0, 255)), 1'b1);
         default: ; // let the next header close the record
      endcase
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Headers without symbols keep counting; a '>' inside a header is a name byte.
      send_text(">H");
      send_beat(8'hFF, 1'b0);
      send_beat(8'h00, 1'b0);
      send_text("\n>>\n");
      // Every base code, '&', an ignored byte and a '>' away from line start.
      send_text("acgtu0123&z!>\n");
      // New header closes the record, then ';' halts until end of input.
      send_text(">\nN;A");
      send_beat(8'hFF, 1'b1);
      send_beat(8'h00, 1'b1);

      while (sent_beats < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 10))
               send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
         else
            random_record();
      end
      send_beat(8'($urandom_range(0, 255)), 1'b1);
      push <= 1'b0;

      while (tracker.pending() > 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      while (reset) @(posedge clock);
      forever begin
         pop_gap = draw_gap(pop_calm);
         if (pop_gap > 0) begin
            pop <= 1'b0;
            repeat (pop_gap) @(posedge clock);
         end
         pop <= 1'b1;
         @(posedge clock);
         while (empty) @(posedge clock);
         tracker.check_result(rsp_data);
      end
   end

endmodule
